[sv/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define KRT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("krt check failed");

// Next-cycle implication, disabled during reset
`define KRT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("krt check failed");

`endif

[sv/krt_pkg.sv]
// Shared types and constants for the keyed record table
package krt_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int VAL_W    = 16;
   localparam int OP_W     = 3;
   localparam int ST_W     = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   typedef logic [OP_W-1:0] op_type;
   typedef logic [ST_W-1:0] status_type;

   localparam op_type OP_ADD    = 3'd0;
   localparam op_type OP_SEARCH = 3'd1;
   localparam op_type OP_UPDATE = 3'd2;
   localparam op_type OP_DELETE = 3'd3;
   localparam op_type OP_LIST   = 3'd4;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NOT_FOUND = 2'd1;
   localparam status_type ST_FULL      = 2'd2;
   localparam status_type ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [VAL_W-1:0]        value;
   } record_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      record_type        wr_data;
   } mem_req_type;

   typedef struct packed {
      status_type              status;
      logic signed [KEY_W-1:0] key;
      logic [VAL_W-1:0]        value;
      logic                    last;
   } result_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_SCAN,
      S_SHIFT,
      S_LIST_RD,
      S_LIST_LD,
      S_EMIT
   } state_type;

endpackage

[sv/krt_store.sv]
// Record memory: one write port, one read port with registered read data
module krt_store (
   input  logic                 clock,
   input  krt_pkg::mem_req_type mem_req,
   output krt_pkg::record_type  rd_data
);

   krt_pkg::record_type mem [krt_pkg::CAPACITY];
   krt_pkg::record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/krt_out.sv]
// Result output register stage
module krt_out (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  krt_pkg::result_type         result,
   input  logic [krt_pkg::CNT_W-1:0]   count,
   output logic                        free,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [krt_pkg::RSP_DATA_W-1:0] rsp_tdata, // out_key, out_value, entries
   output logic [krt_pkg::ST_W-1:0]    rsp_tuser,    // status
   output logic                        rsp_tlast
);

   logic                           valid_ff;
   logic                           valid_in;
   logic [krt_pkg::RSP_DATA_W-1:0] data_ff;
   krt_pkg::status_type            status_ff;
   logic                           last_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff   <= {1'b0, count, result.value, result.key};
         status_ff <= result.status;
         last_ff   <= result.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

endmodule

[sv/krt_seq.sv]
// Operation sequencer with the shared key comparator and record walk counter
module krt_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [krt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [krt_pkg::OP_W-1:0]       req_tuser,
   output krt_pkg::mem_req_type           mem_req,
   input  krt_pkg::record_type            rd_data,
   input  logic                           out_free,
   output logic                           out_load,
   output krt_pkg::result_type            result,
   output logic [krt_pkg::CNT_W-1:0]      count
);

   krt_pkg::state_type state_ff, state_in;
   krt_pkg::op_type    op_ff, op_in;
   logic signed [krt_pkg::KEY_W-1:0] key_ff, key_in;
   logic [krt_pkg::VAL_W-1:0]        value_ff, value_in;
   logic [krt_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [krt_pkg::CNT_W-1:0]        idx_ff, idx_in;
   logic                             pend_ff, pend_in;
   logic [krt_pkg::CNT_W-1:0]        pend_idx_ff, pend_idx_in;
   krt_pkg::result_type              res_ff, res_in;

   logic accept;
   logic rd_more;
   logic hit;
   logic walk_done;
   logic [krt_pkg::CNT_W-1:0] pend_prev;

   assign accept    = req_tvalid && (state_ff == krt_pkg::S_IDLE);
   assign rd_more   = idx_ff < count_ff;
   assign hit       = pend_ff && (rd_data.key == key_ff);
   assign walk_done = !rd_more && !pend_ff;
   assign pend_prev = pend_idx_ff - krt_pkg::CNT_ONE;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         krt_pkg::S_IDLE: begin
            if (req_tvalid) begin
               priority case (req_tuser)
                  krt_pkg::OP_ADD: state_in = krt_pkg::S_ADD;
                  krt_pkg::OP_SEARCH,
                  krt_pkg::OP_UPDATE,
                  krt_pkg::OP_DELETE: state_in = krt_pkg::S_SCAN;
                  krt_pkg::OP_LIST: begin
                     state_in = (count_ff == '0) ? krt_pkg::S_EMIT : krt_pkg::S_LIST_RD;
                  end
                  default: state_in = krt_pkg::S_IDLE;
               endcase
            end
         end
         krt_pkg::S_ADD: state_in = krt_pkg::S_EMIT;
         krt_pkg::S_SCAN: begin
            if (hit) begin
               state_in = (op_ff == krt_pkg::OP_DELETE) ? krt_pkg::S_SHIFT : krt_pkg::S_EMIT;
            end else if (walk_done) begin
               state_in = krt_pkg::S_EMIT;
            end
         end
         krt_pkg::S_SHIFT: begin
            if (walk_done) begin
               state_in = krt_pkg::S_EMIT;
            end
         end
         krt_pkg::S_LIST_RD: state_in = krt_pkg::S_LIST_LD;
         krt_pkg::S_LIST_LD: state_in = krt_pkg::S_EMIT;
         krt_pkg::S_EMIT: begin
            if (out_free) begin
               state_in = res_ff.last ? krt_pkg::S_IDLE : krt_pkg::S_LIST_RD;
            end
         end
         default: state_in = krt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == krt_pkg::S_IDLE);
      out_load   = (state_ff == krt_pkg::S_EMIT) && out_free;
      mem_req    = '0;
      unique case (state_ff)
         krt_pkg::S_ADD: begin
            mem_req.wr_en   = count_ff < krt_pkg::CAP_CNT;
            mem_req.wr_addr = count_ff[krt_pkg::ADDR_W-1:0];
            mem_req.wr_data = '{key: key_ff, value: value_ff};
         end
         krt_pkg::S_SCAN: begin
            mem_req.rd_en   = rd_more;
            mem_req.rd_addr = idx_ff[krt_pkg::ADDR_W-1:0];
            mem_req.wr_en   = hit && (op_ff == krt_pkg::OP_UPDATE);
            mem_req.wr_addr = pend_idx_ff[krt_pkg::ADDR_W-1:0];
            mem_req.wr_data = '{key: rd_data.key, value: value_ff};
         end
         krt_pkg::S_SHIFT: begin
            mem_req.rd_en   = rd_more;
            mem_req.rd_addr = idx_ff[krt_pkg::ADDR_W-1:0];
            mem_req.wr_en   = pend_ff;
            mem_req.wr_addr = pend_prev[krt_pkg::ADDR_W-1:0];
            mem_req.wr_data = rd_data;
         end
         krt_pkg::S_LIST_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_ff[krt_pkg::ADDR_W-1:0];
         end
         default: begin
            mem_req = '0;
         end
      endcase
   end

   always_comb begin
      op_in       = op_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      res_in      = res_ff;
      unique case (state_ff)
         krt_pkg::S_IDLE: begin
            if (accept) begin
               op_in    = req_tuser;
               key_in   = req_tdata[krt_pkg::KEY_W-1:0];
               value_in = req_tdata[krt_pkg::KEY_W +: krt_pkg::VAL_W];
               idx_in   = '0;
               res_in   = '{status: krt_pkg::ST_EMPTY, key: '0, value: '0, last: 1'b1};
            end
         end
         krt_pkg::S_ADD: begin
            if (count_ff < krt_pkg::CAP_CNT) begin
               count_in = count_ff + krt_pkg::CNT_ONE;
               res_in   = '{status: krt_pkg::ST_OK, key: '0, value: '0, last: 1'b1};
            end else begin
               res_in   = '{status: krt_pkg::ST_FULL, key: '0, value: '0, last: 1'b1};
            end
         end
         krt_pkg::S_SCAN: begin
            pend_in     = rd_more;
            pend_idx_in = idx_ff;
            idx_in      = rd_more ? idx_ff + krt_pkg::CNT_ONE : idx_ff;
            if (hit) begin
               pend_in = 1'b0;
               idx_in  = pend_idx_ff + krt_pkg::CNT_ONE;
               res_in  = '{status: krt_pkg::ST_OK, key: rd_data.key,
                           value: rd_data.value, last: 1'b1};
               if (op_ff == krt_pkg::OP_UPDATE) begin
                  res_in.value = value_ff;
               end
            end else if (walk_done) begin
               res_in = '{status: krt_pkg::ST_NOT_FOUND, key: '0, value: '0, last: 1'b1};
            end
         end
         krt_pkg::S_SHIFT: begin
            pend_in     = rd_more;
            pend_idx_in = idx_ff;
            idx_in      = rd_more ? idx_ff + krt_pkg::CNT_ONE : idx_ff;
            if (walk_done) begin
               count_in = count_ff - krt_pkg::CNT_ONE;
            end
         end
         krt_pkg::S_LIST_LD: begin
            res_in = '{status: krt_pkg::ST_OK, key: rd_data.key, value: rd_data.value,
                       last: (idx_ff + krt_pkg::CNT_ONE) == count_ff};
            idx_in = idx_ff + krt_pkg::CNT_ONE;
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= krt_pkg::S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      res_ff      <= res_in;
   end

   assign result = res_ff;
   assign count  = count_ff;

endmodule

[sv/keyed_record_table_top.sv]
// Keyed record table top level: sequencer, record memory and result register
// Each request transaction is one operation on a table of up to 64 key/value records kept in
// insertion order. The block takes one request at a time and drops req_tready until its last
// response has been loaded into the output register. Search and update walk the stored
// records through the single read port of the record memory, one per cycle. Delete walks
// to the first match and then shifts every later record down through the same port. List
// reads, loads and emits each record in turn and waits whenever the response side stalls.
// Operation codes 5 to 7 are consumed without a response. The memory needs no clearing
// after reset.
module keyed_record_table_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [krt_pkg::REQ_DATA_W-1:0] req_tdata,  // key, value
   input  logic [krt_pkg::OP_W-1:0]       req_tuser,  // op
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [krt_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_key, out_value, entries
   output logic [krt_pkg::ST_W-1:0]       rsp_tuser,  // status
   output logic                           rsp_tlast
);

   krt_pkg::mem_req_type mem_req;
   krt_pkg::record_type  rd_data;
   krt_pkg::result_type  result;
   logic                 out_free;
   logic                 out_load;
   logic [krt_pkg::CNT_W-1:0] count;

   krt_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .out_free   (out_free),
      .out_load   (out_load),
      .result     (result),
      .count      (count)
   );

   krt_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   krt_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .result     (result),
      .count      (count),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[sv/krt_checker.sv]
// Port-level checker for the keyed record table, bound to the top level
`include "assert_macros.svh"

module krt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [krt_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [krt_pkg::OP_W-1:0]       req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [krt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [krt_pkg::ST_W-1:0]       rsp_tuser,
   input logic                           rsp_tlast
);

   logic [krt_pkg::CNT_W-1:0] entries;
   logic                      req_valid_op;

   assign entries      = rsp_tdata[krt_pkg::KEY_W + krt_pkg::VAL_W +: krt_pkg::CNT_W];
   assign req_valid_op = !req_tuser[2] || (req_tuser[1:0] == 2'b00);

   `KRT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `KRT_ASSERT_IMP(a_entries_cap, clock, reset, rsp_tvalid, entries <= krt_pkg::CAP_CNT)
   `KRT_ASSERT_IMP(a_full_count, clock, reset, rsp_tvalid && rsp_tuser == krt_pkg::ST_FULL, entries == krt_pkg::CAP_CNT && rsp_tlast)
   `KRT_ASSERT_IMP(a_empty_count, clock, reset, rsp_tvalid && rsp_tuser == krt_pkg::ST_EMPTY, entries == '0 && rsp_tlast)
   `KRT_ASSERT_NXT(a_busy_after_req, clock, reset, req_tvalid && req_tready && req_valid_op, !req_tready)

endmodule

bind keyed_record_table_top krt_checker u_krt_checker (.*);
